FILE: hw/rtl/mt19937_random_generator_macros.svh
// Assertion macros used by the generator RTL.
`ifndef MT19937_RANDOM_GENERATOR_MACROS_SVH
`define MT19937_RANDOM_GENERATOR_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define MT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/mt_pkg.sv
package mt_pkg;
    localparam int unsigned Words = 624;
    localparam int unsigned Shift = 397;
    localparam int unsigned AddrW = 10;
    localparam logic [AddrW-1:0] IdxUnseeded = 10'd625;
    localparam logic [AddrW-1:0] IdxLast = 10'd623;
    localparam logic [AddrW-1:0] IdxWords = 10'd624;
    localparam logic [31:0] Matrix = 32'h9908b0df;
    localparam logic [31:0] TemperB = 32'h9d2c5680;
    localparam logic [31:0] TemperC = 32'hefc60000;
    localparam logic [31:0] SeedMult = 32'd69069;
    localparam logic [31:0] DefaultSeed = 32'd4357;

    localparam logic [1:0] CmdGen = 2'd0;
    localparam logic [1:0] CmdSeed = 2'd1;
    localparam logic [1:0] CmdSave = 2'd2;
    localparam logic [1:0] CmdRestore = 2'd3;

    typedef enum logic [3:0] {
        t_idle_s, t_seed_s, t_twa_s, t_twb_s, t_twc_s, t_twd_s,
        t_gra_s, t_grb_s, t_cpa_s, t_cpb_s, t_out_s
    } t_state;

    function automatic logic [30:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y[30:0];
    endfunction

    function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] f);
        logic [31:0] y;
        y = {a[31], b[30:0]};
        return f ^ (y >> 1) ^ (y[0] ? Matrix : 32'd0);
    endfunction
endpackage

FILE: hw/rtl/mt_ram.sv
module mt_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr_a,
    output logic [Width-1:0]         o_rdata_a,
    input  logic [$clog2(Depth)-1:0] i_raddr_b,
    output logic [Width-1:0]         o_rdata_b
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

FILE: hw/rtl/mt19937_random_generator.sv
// A generate with words left reads the word at the read index (GRA, GRB) and tempers it.
// The next request is taken only after the result leaves, so generates do not overlap.
// A generate that needs regeneration first twists every word (TWA to TWD per word), and an
// unseeded one first seeds with the default seed. A seed fills every word, a save or restore copies them all.
// Reset (synchronous, active low) marks the block unseeded and clears the backup
// index; memory contents are not cleared.
module mt19937_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // command [1:0], seed_value [33:2], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // random_value [30:0], zero [31]
);
`include "mt19937_random_generator_macros.svh"

    mt_pkg::t_state r_state, n_state;
    logic [1:0]  r_cmd, n_cmd;
    logic [31:0] r_seed, n_seed;
    logic [9:0]  r_idx, n_idx;      // read index, 625 when unseeded
    logic [9:0]  r_bidx, n_bidx;    // backup index
    logic [9:0]  r_k, n_k;          // sweep counter
    logic [31:0] r_a, n_a;          // top bit of word k and low bits of word k+1, held between twist steps
    logic [30:0] r_out, n_out;

    // State memory and backup memory.
    logic        we_s, we_b;
    logic [9:0]  wa_s, ra_s, rb_s, wa_b, ra_b;
    logic [31:0] wd_s, qa_s, qb_s, wd_b, qa_b, qb_b;

    mt_ram #(.Width(32), .Depth(mt_pkg::Words)) u_state (
        .i_clk(i_clk), .i_we(we_s), .i_waddr(wa_s), .i_wdata(wd_s),
        .i_raddr_a(ra_s), .o_rdata_a(qa_s), .i_raddr_b(rb_s), .o_rdata_b(qb_s)
    );
    mt_ram #(.Width(32), .Depth(mt_pkg::Words)) u_backup (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(wa_b), .i_wdata(wd_b),
        .i_raddr_a(ra_b), .o_rdata_a(qa_b), .i_raddr_b(ra_b), .o_rdata_b(qb_b)
    );

    logic [9:0] k1, kf;
    always_comb begin
        k1 = (r_k == mt_pkg::IdxLast) ? 10'd0 : r_k + 10'd1;
        kf = (r_k >= 10'(mt_pkg::Words - mt_pkg::Shift)) ?
             r_k - 10'(mt_pkg::Words - mt_pkg::Shift) : r_k + 10'(mt_pkg::Shift);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mt_pkg::t_idle_s;
            r_idx   <= mt_pkg::IdxUnseeded;
            r_bidx  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bidx  <= n_bidx;
        end
        r_cmd  <= n_cmd;
        r_seed <= n_seed;
        r_k    <= n_k;
        r_a    <= n_a;
        r_out  <= n_out;
    end

    // Next state. Twist of word k: read k and k+1 (TWA), read k+397 (TWB, held
    // through TWC), write (TWD).
    // Word k+1 is re-read each step, so earlier writes are always seen.
    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd; n_seed = r_seed; n_idx = r_idx; n_bidx = r_bidx;
        n_k = r_k; n_a = r_a; n_out = r_out;
        case (r_state)
            mt_pkg::t_idle_s: begin
                if (s_axis_tvalid) begin
                    n_cmd = s_axis_tdata[1:0];
                    n_seed = s_axis_tdata[33:2];
                    n_k = '0;
                    n_out = '0;
                    case (s_axis_tdata[1:0])
                        mt_pkg::CmdSeed: n_state = mt_pkg::t_seed_s;
                        mt_pkg::CmdGen: begin
                            if (r_idx == mt_pkg::IdxUnseeded) begin
                                n_seed = mt_pkg::DefaultSeed;
                                n_state = mt_pkg::t_seed_s;
                            end else if (r_idx == mt_pkg::IdxWords) begin
                                n_state = mt_pkg::t_twa_s;
                            end else begin
                                n_state = mt_pkg::t_gra_s;
                            end
                        end
                        default: n_state = mt_pkg::t_cpa_s;
                    endcase
                end
            end
            mt_pkg::t_seed_s: begin
                n_seed = r_seed * mt_pkg::SeedMult;
                n_k = r_k + 10'd1;
                if (r_k == mt_pkg::IdxLast) begin
                    n_idx = mt_pkg::IdxWords;
                    n_k = '0;
                    n_state = (r_cmd == mt_pkg::CmdGen) ? mt_pkg::t_twa_s : mt_pkg::t_out_s;
                end
            end
            mt_pkg::t_twa_s: n_state = mt_pkg::t_twb_s;
            mt_pkg::t_twb_s: begin
                n_a = {qa_s[31], qb_s[30:0]};
                n_state = mt_pkg::t_twc_s;
            end
            mt_pkg::t_twc_s: n_state = mt_pkg::t_twd_s;
            mt_pkg::t_twd_s: begin
                n_k = k1;
                if (r_k == mt_pkg::IdxLast) begin
                    n_idx = '0;
                    n_state = mt_pkg::t_gra_s;
                end else begin
                    n_state = mt_pkg::t_twa_s;
                end
            end
            mt_pkg::t_gra_s: n_state = mt_pkg::t_grb_s;
            mt_pkg::t_grb_s: begin
                n_out = mt_pkg::temper(qa_s);
                n_idx = r_idx + 10'd1;
                n_state = mt_pkg::t_out_s;
            end
            mt_pkg::t_cpa_s: begin
                n_k = r_k + 10'd1;
                n_state = mt_pkg::t_cpb_s;
            end
            mt_pkg::t_cpb_s: begin
                // One word is copied per cycle, write lags read by one.
                n_k = r_k + 10'd1;
                if (r_k == mt_pkg::IdxWords) begin
                    if (r_cmd == mt_pkg::CmdSave) n_bidx = r_idx;
                    else n_idx = r_bidx;
                    n_state = mt_pkg::t_out_s;
                end
            end
            mt_pkg::t_out_s: if (m_axis_tready) n_state = mt_pkg::t_idle_s;
            default: n_state = mt_pkg::t_idle_s;
        endcase
    end

    // Outputs and memory controls.
    always_comb begin
        s_axis_tready = (r_state == mt_pkg::t_idle_s);
        m_axis_tvalid = (r_state == mt_pkg::t_out_s);
        m_axis_tdata  = {1'b0, r_out};
        we_s = 1'b0; wa_s = r_k; wd_s = r_seed; ra_s = r_k; rb_s = k1;
        we_b = 1'b0; wa_b = r_k - 10'd1; wd_b = qa_s; ra_b = r_k;
        case (r_state)
            mt_pkg::t_seed_s: we_s = 1'b1;
            mt_pkg::t_twb_s, mt_pkg::t_twc_s: rb_s = kf;
            mt_pkg::t_twd_s: begin
                we_s = 1'b1;
                wd_s = mt_pkg::twist(r_a, r_a, qb_s);
            end
            mt_pkg::t_gra_s: ra_s = r_idx;
            mt_pkg::t_cpb_s: begin
                if (r_cmd == mt_pkg::CmdSave) we_b = 1'b1;
                else begin
                    we_s = 1'b1;
                    wa_s = r_k - 10'd1;
                    wd_s = qa_b;
                end
            end
            default: ;
        endcase
    end

    logic unused_q;
    assign unused_q = ^qb_b;

    `MT_ASSERT_IMP(a_out_only_ready_idle, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `MT_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= mt_pkg::IdxUnseeded)
    `MT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))
endmodule

FILE: tb/mt_result_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the generator, predicts each result from the
// accepted requests and compares it with what the block returns.
module mt_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [39:0] i_req_data,     // command [1:0], seed_value [33:2], zeros
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_rsp_data,     // random_value [30:0], zero [31]
    output int          o_fail_count,
    output int          o_pending
);
    logic [31:0] mt_words [mt_pkg::Words];
    logic [31:0] saved_words [mt_pkg::Words];
    logic [9:0]  mt_index;
    logic [9:0]  saved_index;
    logic [30:0] expected_randoms [$];

    function automatic void load_seed(input logic [31:0] s);
        mt_words[0] = s;
        for (int i = 1; i < mt_pkg::Words; i++) begin
            mt_words[i] = mt_words[i-1] * 32'd69069;
        end
        mt_index = 10'd624;
    endfunction

    function automatic void regenerate();
        logic [31:0] y;
        logic [31:0] v;
        for (int k = 0; k < mt_pkg::Words; k++) begin
            y = {mt_words[k][31], mt_words[(k + 1) % mt_pkg::Words][30:0]};
            v = mt_words[(k + mt_pkg::Shift) % mt_pkg::Words] ^ (y >> 1);
            if (y[0]) begin
                v = v ^ 32'h9908b0df;
            end
            mt_words[k] = v;
        end
        mt_index = 10'd0;
    endfunction

    function automatic logic [30:0] draw_random();
        logic [31:0] y;
        if (mt_index >= 10'd624) begin
            if (mt_index == 10'd625) begin
                load_seed(32'd4357);
            end
            regenerate();
        end
        y = mt_words[mt_index];
        mt_index = mt_index + 10'd1;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y[30:0];
    endfunction

    function automatic logic [30:0] apply_request(input logic [1:0] cmd,
                                                  input logic [31:0] seed);
        logic [30:0] r;
        r = '0;
        case (cmd)
            mt_pkg::CmdGen: begin
                r = draw_random();
            end
            mt_pkg::CmdSeed: begin
                load_seed(seed);
            end
            mt_pkg::CmdSave: begin
                saved_index = mt_index;
                saved_words = mt_words;
            end
            default: begin
                mt_index = saved_index;
                mt_words = saved_words;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic [30:0] want;
        if (!i_rst_n) begin
            mt_index = 10'd625;
            saved_index = 10'd0;
            expected_randoms.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_req_valid && i_req_ready) begin
                expected_randoms.push_back(apply_request(i_req_data[1:0], i_req_data[33:2]));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_randoms.size() == 0) begin
                    $error("random_value: none expected, got %h", i_rsp_data[30:0]);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_randoms.pop_front();
                    if (want !== i_rsp_data[30:0]) begin
                        $error("random_value: expected %h, got %h", want, i_rsp_data[30:0]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_randoms.size();
        end
    end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;      // command [1:0], seed_value [33:2], zeros
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;      // random_value [30:0], zero [31]
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          sent_count;
    int          rcvd_count;

    mt19937_random_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mt_result_checker u_result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The watchdog allows for every request being a seed or a snapshot copy, plus
    // the full regeneration passes, with both sides idling at their longest.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 20000000) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Sends one request. The valid stays high from one request to the next when
    // no gap is drawn, so it is never lowered and raised in the same time step.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] seed);
        int gap;
        gap = ((sent_count % 160) < 40) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, seed, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    // Random requests are mostly generates so that the word index runs through
    // several regeneration passes; seeds and snapshot copies are mixed in.
    task automatic send_random_request();
        int pick;
        logic [31:0] seed;
        pick = $urandom_range(0, 99);
        seed = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
        if (pick < 88) begin
            send_request(mt_pkg::CmdGen, seed);
        end else if (pick < 94) begin
            send_request(mt_pkg::CmdSeed, seed);
        end else if (pick < 97) begin
            send_request(mt_pkg::CmdSave, seed);
        end else begin
            send_request(mt_pkg::CmdRestore, seed);
        end
    endtask

    // The receiver stalls a random number of cycles before each result, except
    // during bursts. Once it holds off for a long stretch so that the block
    // keeps its result and refuses further requests.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rcvd_count == 300) begin
                stall = 3000;
            end else if ((rcvd_count % 128) < 32) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 11);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            rcvd_count++;
        end
    end

    initial begin
        cycle_count   = 0;
        sent_count    = 0;
        rcvd_count    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A generate before any seed makes the block seed itself with the
        // default value, and the save after it stores that state and its index.
        send_request(mt_pkg::CmdGen, 32'hFFFFFFFF);
        send_request(mt_pkg::CmdSave, 32'h0);
        // A zero seed clears every word, so the outputs stay zero.
        send_request(mt_pkg::CmdSeed, 32'h0);
        send_request(mt_pkg::CmdGen, 32'h0);
        send_request(mt_pkg::CmdGen, 32'hA5A5A5A5);
        // Restoring that snapshot brings the default-seeded state back.
        send_request(mt_pkg::CmdRestore, 32'h5A5A5A5A);
        send_request(mt_pkg::CmdGen, 32'h0);
        send_request(mt_pkg::CmdGen, 32'h0);
        send_request(mt_pkg::CmdSeed, 32'hFFFFFFFF);
        send_request(mt_pkg::CmdGen, 32'h0);
        send_request(mt_pkg::CmdGen, 32'hFFFFFFFF);
        send_request(mt_pkg::CmdSave, 32'hFFFFFFFF);
        send_request(mt_pkg::CmdGen, 32'h0);
        send_request(mt_pkg::CmdGen, 32'h0);
        send_request(mt_pkg::CmdRestore, 32'h0);
        send_request(mt_pkg::CmdGen, 32'h0);
        send_request(mt_pkg::CmdGen, 32'h0);
        send_request(mt_pkg::CmdSeed, 32'h1);
        send_request(mt_pkg::CmdGen, 32'h0);
        send_request(mt_pkg::CmdSeed, 32'h80000000);
        send_request(mt_pkg::CmdGen, 32'h7FFFFFFF);
        send_request(mt_pkg::CmdSeed, 32'h7FFFFFFF);
        send_request(mt_pkg::CmdGen, 32'h0);

        repeat (1400) send_random_request();
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (3200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
